>>> sv/bsd_pkg.sv
`timescale 1ns / 1ps

package bsd_pkg;

  localparam int BLOCK_ELEMS   = 32;
  localparam int LANES         = 8;
  localparam int ELEMS_PER_LANE = BLOCK_ELEMS / LANES;
  localparam int BYTE_W        = 8;
  localparam int LANE_DATA_W   = ELEMS_PER_LANE * BYTE_W;
  localparam int WORD_W        = 64;
  localparam int F32_W         = 32;
  localparam int F32_MANT      = 23;
  localparam int F32_SIG       = F32_MANT + 1;
  localparam int F32_BIAS_LSB  = 150;   // bias plus fraction width
  localparam int F32_EXP_MAX   = 255;
  localparam int LSB_EXP_MIN   = -149;  // lsb weight of a subnormal

  // exact operand: value = mant * 2^exp
  localparam int EXP_W   = 12;
  localparam int MANT_W  = 2 * F32_SIG;           // room for a 24x24 product
  localparam int ALIGN_W = MANT_W + 3;            // guard bits kept on alignment
  localparam int AL_W    = MANT_W + ALIGN_W;
  localparam int SUM_W   = AL_W + 1;
  localparam int LZ_W    = $clog2(SUM_W);
  localparam int LSUM_W  = 18;                    // exact sum of four int8 products

  localparam logic [F32_W-1:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [F32_W-1:0] F32_ZERO = 32'h0000_0000;

  typedef struct packed {
    logic             nan;
    logic             inf;
    logic             zero;
    logic             sign;
    logic [EXP_W-1:0] exp;
    logic [MANT_W-1:0] mant;
  } fop_t;

  typedef struct packed {
    logic nan;
    logic inf;
    logic inf_sign;
    logic both_zero;
    logic zero_sign;
  } fspec_t;

  // neutral addend: -0 leaves every value, signed zeros included, unchanged
  localparam fop_t FOP_NEG_ZERO = '{nan: 1'b0, inf: 1'b0, zero: 1'b1, sign: 1'b1,
                                    exp: '0, mant: '0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_LANES,
    ST_LANE_WAIT,
    ST_MERGE,
    ST_MERGE_WAIT
  } bsd_state_t;

  typedef enum logic [2:0] {
    MS_H0,
    MS_H1,
    MS_H2,
    MS_H3,
    MS_Q0,
    MS_Q1,
    MS_SUM,
    MS_BIAS
  } merge_step_t;

  function automatic fop_t f32_unpack(input logic [F32_W-1:0] b);
    fop_t       r;
    logic [7:0] e;
    logic [F32_MANT-1:0] f;
    e = b[30:23];
    f = b[F32_MANT-1:0];
    r.nan  = (e == 8'hFF) && (f != '0);
    r.inf  = (e == 8'hFF) && (f == '0);
    r.zero = (e == 8'h00) && (f == '0);
    r.sign = b[31];
    if (e == 8'h00) begin
      r.exp = EXP_W'(LSB_EXP_MIN);
    end else begin
      r.exp = EXP_W'({4'b0, e}) - EXP_W'(F32_BIAS_LSB);
    end
    r.mant = MANT_W'({(e != 8'h00), f});
    return r;
  endfunction

endpackage

>>> sv/block_scaled_int8_dot_product.sv
`timescale 1ns / 1ps

// block-scaled int8 dot product with float32 accumulation
// in_*: one item is one 32-element block: four activation words, four weight
//   words, the activation and weight scales and the bias, all float32 bits;
//   in_tlast marks the final block of a dot product
// out_*: one float32 result for each block that carries in_tlast
// eight lanes each take four elements, form an exact integer sum, multiply it
//   by the rounded scale product and fuse it into their float32 accumulator;
//   a merge stage reduces the lanes and adds the bias on the last block
// rate: one block at a time; in_tready returns only after the lanes have
//   accumulated a block without in_tlast; the 4-stage float adder is passed
//   twice in series (scale product adder, then the lane accumulate adders)
// on the last block the merge stage runs 8 adds in series, each issued once
//   the previous sum has returned; the last of them gives the result
// reset: all accumulators are +0.0 and no result is pending; the lanes are
//   cleared again after each result
// a stalled receiver holds the result in the output register; the next block
//   is still accepted and processed, only its own reduction waits for the
//   output register to empty

module block_scaled_int8_dot_product import bsd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // act_bytes_0..3, weight_bytes_0..3, act_scale, weight_scale, bias_bits
  input  logic [607:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_bits
  output logic [31:0]  out_tdata
);

  localparam int ACT_W = BLOCK_ELEMS * BYTE_W;

  bsd_state_t state_r, state_nxt;

  logic [ACT_W-1:0] act_r, wgt_r;
  logic [F32_W-1:0] ascale_r, wscale_r, bias_r, mul_bits_r;
  logic             last_r;
  fop_t             prod_op_r, prod_nxt, ua, ub;

  logic             accept;
  logic             scale_issue, scale_valid;
  logic [F32_W-1:0] scale_bits;
  logic             lane_start, merge_start, merge_done;
  logic [LANES-1:0] lane_done;
  logic [LANES-1:0][F32_W-1:0] lane_acc;
  logic [F32_W-1:0] merge_result;
  logic             out_tvalid_r;
  logic [F32_W-1:0] out_data_r;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // exact product of the two scales, rounded by the adder with a -0 addend
  always_comb begin
    ua            = f32_unpack(ascale_r);
    ub            = f32_unpack(wscale_r);
    prod_nxt.nan  = ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf);
    prod_nxt.inf  = ua.inf || ub.inf;
    prod_nxt.zero = ua.zero || ub.zero;
    prod_nxt.sign = ua.sign ^ ub.sign;
    prod_nxt.exp  = ua.exp + ub.exp;
    prod_nxt.mant = ua.mant[F32_SIG-1:0] * ub.mant[F32_SIG-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    scale_issue = 1'b0;
    lane_start  = 1'b0;
    merge_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_PROD;
      end
      ST_PROD:  state_nxt = ST_SCALE;
      ST_SCALE: begin
        scale_issue = 1'b1;
        state_nxt   = ST_SCALE_WAIT;
      end
      ST_SCALE_WAIT: begin
        if (scale_valid) state_nxt = ST_LANES;
      end
      ST_LANES: begin
        lane_start = 1'b1;
        state_nxt  = ST_LANE_WAIT;
      end
      ST_LANE_WAIT: begin
        if (lane_done[0]) state_nxt = last_r ? ST_MERGE : ST_IDLE;
      end
      ST_MERGE: begin
        // reduction starts only with the output register free
        if (!out_tvalid_r) begin
          merge_start = 1'b1;
          state_nxt   = ST_MERGE_WAIT;
        end
      end
      ST_MERGE_WAIT: begin
        if (merge_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_tdata[ACT_W-1:0];
      wgt_r    <= in_tdata[2*ACT_W-1:ACT_W];
      ascale_r <= in_tdata[2*ACT_W +: F32_W];
      wscale_r <= in_tdata[2*ACT_W+F32_W +: F32_W];
      bias_r   <= in_tdata[2*ACT_W+2*F32_W +: F32_W];
      last_r   <= in_tlast;
    end
    if (state_r == ST_PROD) begin
      prod_op_r <= prod_nxt;
    end
    if (scale_valid) begin
      mul_bits_r <= scale_bits;
    end
  end

  bsd_fadd u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (scale_issue),
    .op_a     (prod_op_r),
    .op_b     (FOP_NEG_ZERO),
    .out_valid(scale_valid),
    .out_bits (scale_bits)
  );

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    bsd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .start     (lane_start),
      .clear     (merge_done),
      .act       (act_r[LANE_DATA_W*j +: LANE_DATA_W]),
      .wgt       (wgt_r[LANE_DATA_W*j +: LANE_DATA_W]),
      .scale_bits(mul_bits_r),
      .done      (lane_done[j]),
      .acc       (lane_acc[j])
    );
  end

  bsd_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (merge_start),
    .lane_acc(lane_acc),
    .bias    (bias_r),
    .done    (merge_done),
    .result  (merge_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (merge_done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (merge_done) begin
      out_data_r <= merge_result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // all lanes finish together
  a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done != '0) |-> (&lane_done))
    else $error("lanes finished out of step");

  a_lane_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (state_r == ST_LANE_WAIT))
    else $error("lane result outside lane wait");

  a_scale_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    scale_valid |-> (state_r == ST_SCALE_WAIT))
    else $error("scale product outside scale wait");

  a_merge_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    merge_done |-> !out_tvalid_r)
    else $error("result overwrote a pending result");

endmodule

>>> sv/bsd_fadd.sv
`timescale 1ns / 1ps

module bsd_fadd import bsd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  fop_t             op_a,
  input  fop_t             op_b,
  output logic             out_valid,
  output logic [F32_W-1:0] out_bits
);

  // stage 1: align the smaller-exponent operand, keep a sticky bit
  logic             s1_v_r;
  logic [AL_W-1:0]  s1_big_r, s1_small_r;
  logic             s1_sb_r, s1_ss_r;
  logic [EXP_W-1:0] s1_e_r;
  fspec_t           s1_sp_r;

  logic             a_big;
  fop_t             big_op, small_op;
  logic [EXP_W-1:0] diff, d_u;
  logic [AL_W-1:0]  small_w, small_sh, s1_small_nxt;
  logic             lost;
  fspec_t           sp_nxt;

  always_comb begin
    if (op_b.zero) begin
      a_big = 1'b1;
    end else if (op_a.zero) begin
      a_big = 1'b0;
    end else begin
      a_big = ($signed(op_a.exp) >= $signed(op_b.exp));
    end
    big_op   = a_big ? op_a : op_b;
    small_op = a_big ? op_b : op_a;
    diff     = big_op.exp - small_op.exp;
    d_u      = diff[EXP_W-1] ? '0 : diff;
    small_w  = {small_op.mant, {ALIGN_W{1'b0}}};
    small_sh = small_w >> d_u;
    lost     = ((small_sh << d_u) != small_w);
    s1_small_nxt = small_sh | AL_W'(lost);
    sp_nxt.nan       = op_a.nan || op_b.nan ||
                       (op_a.inf && op_b.inf && (op_a.sign != op_b.sign));
    sp_nxt.inf       = op_a.inf || op_b.inf;
    sp_nxt.inf_sign  = op_a.inf ? op_a.sign : op_b.sign;
    sp_nxt.both_zero = op_a.zero && op_b.zero;
    sp_nxt.zero_sign = op_a.sign && op_b.sign;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
    end
    s1_big_r   <= {big_op.mant, {ALIGN_W{1'b0}}};
    s1_small_r <= s1_small_nxt;
    s1_sb_r    <= big_op.sign;
    s1_ss_r    <= small_op.sign;
    s1_e_r     <= big_op.exp;
    s1_sp_r    <= sp_nxt;
  end

  // stage 2: signed-magnitude add
  logic             s2_v_r;
  logic [SUM_W-1:0] s2_mag_r, mag_nxt;
  logic             s2_sgn_r, sgn_nxt;
  logic [EXP_W-1:0] s2_e_r;
  fspec_t           s2_sp_r;

  always_comb begin
    if (s1_sb_r == s1_ss_r) begin
      mag_nxt = {1'b0, s1_big_r} + {1'b0, s1_small_r};
      sgn_nxt = s1_sb_r;
    end else if (s1_big_r >= s1_small_r) begin
      mag_nxt = {1'b0, s1_big_r} - {1'b0, s1_small_r};
      sgn_nxt = s1_sb_r;
    end else begin
      mag_nxt = {1'b0, s1_small_r} - {1'b0, s1_big_r};
      sgn_nxt = s1_ss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_mag_r <= mag_nxt;
    s2_sgn_r <= sgn_nxt;
    s2_e_r   <= s1_e_r;
    s2_sp_r  <= s1_sp_r;
  end

  // stage 3: leading one, result lsb weight and drop count
  logic             s3_v_r;
  logic [SUM_W-1:0] s3_mag_r;
  logic             s3_sgn_r;
  logic [EXP_W-1:0] s3_lexp_r, s3_k_r;
  fspec_t           s3_sp_r;

  logic [LZ_W-1:0]         lead;
  logic signed [EXP_W-1:0] e_lsb, e_msb, lexp_nxt, k_nxt;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SUM_W; i++) begin
      if (s2_mag_r[i]) begin
        lead = LZ_W'(i);
      end
    end
    e_lsb = $signed(s2_e_r) - $signed(EXP_W'(ALIGN_W));
    e_msb = e_lsb + $signed({{(EXP_W-LZ_W){1'b0}}, lead});
    if ((e_msb - $signed(EXP_W'(F32_MANT))) < $signed(EXP_W'(LSB_EXP_MIN))) begin
      lexp_nxt = $signed(EXP_W'(LSB_EXP_MIN));
    end else begin
      lexp_nxt = e_msb - $signed(EXP_W'(F32_MANT));
    end
    k_nxt = lexp_nxt - e_lsb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_mag_r  <= s2_mag_r;
    s3_sgn_r  <= s2_sgn_r;
    s3_lexp_r <= lexp_nxt;
    s3_k_r    <= k_nxt;
    s3_sp_r   <= s2_sp_r;
  end

  // stage 4: shift to the result lsb, round to nearest even, pack
  logic [F32_SIG-1:0]      m, mant;
  logic [F32_SIG:0]        mr;
  logic [SUM_W-1:0]        t;
  logic [EXP_W-1:0]        km1;
  logic                    g, st, up;
  logic signed [EXP_W-1:0] lexp2, ebias;
  logic [F32_W-1:0]        bits_nxt;

  always_comb begin
    g   = 1'b0;
    st  = 1'b0;
    km1 = s3_k_r - EXP_W'(1);
    t   = s3_mag_r >> km1;
    if (s3_k_r[EXP_W-1]) begin
      m = F32_SIG'(s3_mag_r << (EXP_W'(0) - s3_k_r));
    end else if (s3_k_r == '0) begin
      m = s3_mag_r[F32_SIG-1:0];
    end else begin
      g  = t[0];
      m  = F32_SIG'(t >> 1);
      st = ((t << km1) != s3_mag_r);
    end
    up = g && (st || m[0]);
    mr = {1'b0, m} + (F32_SIG+1)'(up);
    if (mr[F32_SIG]) begin
      mant  = mr[F32_SIG:1];
      lexp2 = $signed(s3_lexp_r) + $signed(EXP_W'(1));
    end else begin
      mant  = mr[F32_SIG-1:0];
      lexp2 = $signed(s3_lexp_r);
    end
    ebias = mant[F32_MANT] ? (lexp2 + $signed(EXP_W'(F32_BIAS_LSB))) : '0;
    if (s3_sp_r.nan) begin
      bits_nxt = F32_QNAN;
    end else if (s3_sp_r.inf) begin
      bits_nxt = {s3_sp_r.inf_sign, 8'hFF, {F32_MANT{1'b0}}};
    end else if (s3_mag_r == '0) begin
      bits_nxt = s3_sp_r.both_zero ? {s3_sp_r.zero_sign, {(F32_W-1){1'b0}}} : F32_ZERO;
    end else if (ebias >= $signed(EXP_W'(F32_EXP_MAX))) begin
      bits_nxt = {s3_sgn_r, 8'hFF, {F32_MANT{1'b0}}};
    end else begin
      bits_nxt = {s3_sgn_r, ebias[7:0], mant[F32_MANT-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s3_v_r;
    end
    out_bits <= bits_nxt;
  end

endmodule

>>> sv/bsd_lane.sv
`timescale 1ns / 1ps

module bsd_lane import bsd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   clear,
  input  logic [LANE_DATA_W-1:0] act,
  input  logic [LANE_DATA_W-1:0] wgt,
  input  logic [F32_W-1:0]       scale_bits,
  output logic                   done,
  output logic [F32_W-1:0]       acc
);

  logic                     v1_r, v2_r;
  logic signed [LSUM_W-1:0] sum_r, sum_nxt;
  fop_t                     op_r, op_nxt, sc;
  logic [LSUM_W-2:0]        sum_mag;
  logic [F32_W-1:0]         acc_r, add_bits;
  logic                     add_valid;

  // exact int8 dot product of this lane's elements
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < ELEMS_PER_LANE; i++) begin
      sum_nxt = sum_nxt + LSUM_W'($signed(act[BYTE_W*i +: BYTE_W]) *
                                  $signed(wgt[BYTE_W*i +: BYTE_W]));
    end
  end

  // exact product of the integer sum and the scale
  always_comb begin
    sc          = f32_unpack(scale_bits);
    sum_mag     = sum_r[LSUM_W-1] ? (LSUM_W-1)'(-sum_r) : sum_r[LSUM_W-2:0];
    op_nxt.nan  = sc.nan || (sc.inf && (sum_r == '0));
    op_nxt.inf  = sc.inf;
    op_nxt.zero = sc.zero || (sum_r == '0);
    op_nxt.sign = sum_r[LSUM_W-1] ^ sc.sign;
    op_nxt.exp  = sc.exp;
    op_nxt.mant = MANT_W'(sum_mag * sc.mant[F32_SIG-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      acc_r <= F32_ZERO;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      if (clear) begin
        acc_r <= F32_ZERO;
      end else if (add_valid) begin
        acc_r <= add_bits;
      end
    end
    sum_r <= sum_nxt;
    op_r  <= op_nxt;
  end

  bsd_fadd u_fadd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v2_r),
    .op_a     (op_r),
    .op_b     (f32_unpack(acc_r)),
    .out_valid(add_valid),
    .out_bits (add_bits)
  );

  assign done = add_valid;
  assign acc  = acc_r;

endmodule

>>> sv/bsd_merge.sv
`timescale 1ns / 1ps

module bsd_merge import bsd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [LANES-1:0][F32_W-1:0] lane_acc,
  input  logic [F32_W-1:0]            bias,
  output logic                        done,
  output logic [F32_W-1:0]            result
);

  merge_step_t      step_r;
  logic             busy_r, pend_r, done_r;
  logic [F32_W-1:0] h0_r, h1_r, h2_r, h3_r, result_r;
  logic [F32_W-1:0] a_bits, b_bits, add_bits;
  logic             issue, add_valid;

  assign issue = busy_r && !pend_r;

  // fixed reduction order: pairs j and j+4, then (h0+h2)+(h1+h3), then bias
  always_comb begin
    unique case (step_r)
      MS_H0:   begin a_bits = lane_acc[0]; b_bits = lane_acc[4]; end
      MS_H1:   begin a_bits = lane_acc[1]; b_bits = lane_acc[5]; end
      MS_H2:   begin a_bits = lane_acc[2]; b_bits = lane_acc[6]; end
      MS_H3:   begin a_bits = lane_acc[3]; b_bits = lane_acc[7]; end
      MS_Q0:   begin a_bits = h0_r;        b_bits = h2_r;        end
      MS_Q1:   begin a_bits = h1_r;        b_bits = h3_r;        end
      MS_SUM:  begin a_bits = h0_r;        b_bits = h1_r;        end
      MS_BIAS: begin a_bits = h0_r;        b_bits = bias;        end
      default: begin a_bits = h0_r;        b_bits = bias;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= MS_H0;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r <= MS_H0;
        busy_r <= 1'b1;
        pend_r <= 1'b0;
      end else if (issue) begin
        pend_r <= 1'b1;
      end else if (add_valid && busy_r) begin
        pend_r <= 1'b0;
        if (step_r == MS_BIAS) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= merge_step_t'(step_r + 3'd1);
        end
      end
    end
    if (add_valid) begin
      unique case (step_r) inside
        MS_H0, MS_Q0, MS_SUM: h0_r <= add_bits;
        MS_H1, MS_Q1:         h1_r <= add_bits;
        MS_H2:                h2_r <= add_bits;
        MS_H3:                h3_r <= add_bits;
        MS_BIAS:              result_r <= add_bits;
        default:              result_r <= add_bits;
      endcase
    end
  end

  bsd_fadd u_fadd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (issue),
    .op_a     (f32_unpack(a_bits)),
    .op_b     (f32_unpack(b_bits)),
    .out_valid(add_valid),
    .out_bits (add_bits)
  );

  assign done   = done_r;
  assign result = result_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bsd_pkg::*;

  // one 32-element block as the sender offers it
  typedef struct {
    logic [3:0][63:0] act;
    logic [3:0][63:0] wgt;
    logic [31:0]      act_scale;
    logic [31:0]      wgt_scale;
    logic [31:0]      bias;
    logic             last;
  } block_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // act_bytes_0..3, weight_bytes_0..3, act_scale, weight_scale, bias_bits
  logic [607:0] in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  // result_bits
  logic [31:0]  out_tdata;

  block_scaled_int8_dot_product dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor state: float32 lane accumulators
  logic [31:0] lane_acc [LANES];

  block_t      block_q[$];      // blocks waiting to be offered
  logic [31:0] dot_q[$];        // dot products still owed by the block
  block_t      cur_block;
  logic        took_block;      // handshake seen at the last rising edge
  int          gap_left;
  int          blocks_taken;
  int          mismatches;
  int          failures;
  logic        hold_off;        // long receiver stall

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // ---------------------------------------------------------------- float helpers

  function automatic real f32_to_real(input logic [31:0] b);
    int  e;
    real v;
    e = b[30:23];
    if (e == 255) begin
      if (b[22:0] != 0) return $bitstoreal(64'h7FF8_0000_0000_0000);
      v = $bitstoreal(64'h7FF0_0000_0000_0000);
    end else if (e == 0) begin
      v = real'(b[22:0]) * (2.0 ** (-149));
    end else begin
      v = real'({1'b1, b[22:0]}) * (2.0 ** (e - 150));
    end
    return b[31] ? -v : v;
  endfunction

  // round a double to float32 bits, nearest even, nan made canonical
  function automatic logic [31:0] real_to_f32(input real d);
    logic [63:0] db, m, kept, rem, half;
    int          e, shift;
    logic        s;
    db = $realtobits(d);
    s  = db[63];
    e  = db[62:52];
    if (e == 2047) return (db[51:0] != 0) ? F32_QNAN : {s, 8'hFF, 23'h0};
    if (e == 0) return {s, 31'h0};      // double zero or far below float range
    e = e - 1023;
    m = {11'h0, 1'b1, db[51:0]};
    shift = (e >= -126) ? 29 : 29 + (-126 - e);
    if (shift > 60) return {s, 31'h0};
    kept = m >> shift;
    rem  = m & ((64'h1 << shift) - 1);
    half = 64'h1 << (shift - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    if (e < -126) return {s, kept[30:0]};  // subnormal, may carry into the smallest normal
    if (kept[24]) begin
      kept = kept >> 1;
      e = e + 1;
    end
    if (e > 127) return {s, 8'hFF, 23'h0};
    return {s, 8'(e + 127), kept[22:0]};
  endfunction

  // single-rounding fused multiply-add: exact product, round-to-odd double sum
  function automatic logic [31:0] fused_mul_add(input real x, input real y, input real z);
    real         p, s, bb, err;
    logic [63:0] sb;
    p = x * y;
    s = p + z;
    if (s - s == 0.0) begin
      bb  = s - p;
      err = (p - (s - bb)) + (z - bb);
      if (err != 0.0) begin
        sb = $realtobits(s);
        if (!sb[0]) begin
          if ((err > 0.0) == (s > 0.0)) sb = sb + 1;
          else sb = sb - 1;
          s = $bitstoreal(sb);
        end
      end
    end
    return real_to_f32(s);
  endfunction

  function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
    return real_to_f32(f32_to_real(a) + f32_to_real(b));
  endfunction

  // ---------------------------------------------------------------- predictor

  task automatic accumulate_block(input block_t blk);
    real         scale;
    int          sum;
    logic [7:0]  ab, wb;
    logic [31:0] h0, h1, h2, h3, y;
    scale = f32_to_real(real_to_f32(f32_to_real(blk.act_scale) * f32_to_real(blk.wgt_scale)));
    for (int j = 0; j < LANES; j++) begin
      sum = 0;
      for (int k = 0; k < ELEMS_PER_LANE; k++) begin
        ab = blk.act[(4*j+k)/8][8*((4*j+k)%8) +: 8];
        wb = blk.wgt[(4*j+k)/8][8*((4*j+k)%8) +: 8];
        sum += int'($signed(ab)) * int'($signed(wb));
      end
      lane_acc[j] = fused_mul_add(real'(sum), scale, f32_to_real(lane_acc[j]));
    end
    if (blk.last) begin
      // fixed reduction tree: j with j+4, then (h0+h2)+(h1+h3), then bias
      h0 = add_f32(lane_acc[0], lane_acc[4]);
      h1 = add_f32(lane_acc[1], lane_acc[5]);
      h2 = add_f32(lane_acc[2], lane_acc[6]);
      h3 = add_f32(lane_acc[3], lane_acc[7]);
      y  = add_f32(add_f32(h0, h2), add_f32(h1, h3));
      dot_q.push_back(add_f32(y, blk.bias));
      for (int j = 0; j < LANES; j++) lane_acc[j] = F32_ZERO;
    end
  endtask

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] rand_float();
    logic [31:0] odd [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                             32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF};
    case ($urandom_range(15))
      0:       return $urandom;
      1:       return odd[$urandom_range(7)];
      default: return {1'($urandom), 8'($urandom_range(140, 110)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [63:0] rand_word();
    logic [7:0]  pick [5] = '{8'h80, 8'h7F, 8'hFF, 8'h00, 8'h01};
    logic [63:0] w;
    case ($urandom_range(9))
      0: for (int i = 0; i < 8; i++) w[8*i +: 8] = pick[$urandom_range(4)];
      1: w = {8{8'h80}};
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  function automatic block_t fill_block(input logic [7:0] a, input logic [7:0] w,
                                        input logic [31:0] sa, input logic [31:0] sw,
                                        input logic [31:0] bias, input logic last);
    block_t b;
    for (int k = 0; k < 4; k++) begin
      b.act[k] = {8{a}};
      b.wgt[k] = {8{w}};
    end
    b.act_scale = sa;
    b.wgt_scale = sw;
    b.bias = bias;
    b.last = last;
    return b;
  endfunction

  function automatic block_t rand_block(input logic last);
    block_t b;
    for (int k = 0; k < 4; k++) begin
      b.act[k] = rand_word();
      b.wgt[k] = rand_word();
    end
    b.act_scale = rand_float();
    b.wgt_scale = rand_float();
    b.bias = ($urandom_range(3) == 0) ? 32'h0 : rand_float();
    b.last = last;
    return b;
  endfunction

  // ---------------------------------------------------------------- test plan

  initial begin
    int     flen;
    block_t b;
    rst_n = 1'b0;
    for (int j = 0; j < LANES; j++) lane_acc[j] = F32_ZERO;

    // largest positive and negative products, scale 1.0
    block_q.push_back(fill_block(8'h80, 8'h80, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 1'b1));
    block_q.push_back(fill_block(8'h7F, 8'h80, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 1'b1));
    // bias ignored on a non-last block, then used on the last one
    block_q.push_back(fill_block(8'h01, 8'h7F, 32'h3F00_0000, 32'h4000_0000, 32'h7F80_0000, 1'b0));
    block_q.push_back(fill_block(8'hFF, 8'h01, 32'h3F80_0000, 32'h3F80_0000, 32'h4120_0000, 1'b1));
    // signed zeros: zero sums with negative scale, negative zero bias
    block_q.push_back(fill_block(8'h00, 8'h7F, 32'hBF80_0000, 32'h3F80_0000, 32'h8000_0000, 1'b1));
    block_q.push_back(fill_block(8'h00, 8'h00, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
    // infinite scale against a zero sum gives nan
    block_q.push_back(fill_block(8'h00, 8'h05, 32'h7F80_0000, 32'h3F80_0000, 32'h0, 1'b1));
    // nan scale, nan bias
    block_q.push_back(fill_block(8'h11, 8'h22, 32'h7FC0_0001, 32'h3F80_0000, 32'h0, 1'b1));
    block_q.push_back(fill_block(8'h11, 8'h22, 32'h3F80_0000, 32'h3F80_0000, 32'hFFFF_FFFF, 1'b1));
    // overflow in the scale product and in the accumulators
    block_q.push_back(fill_block(8'h7F, 8'h7F, 32'h7F7F_FFFF, 32'h4000_0000, 32'h0, 1'b1));
    block_q.push_back(fill_block(8'h80, 8'h80, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h0, 1'b0));
    block_q.push_back(fill_block(8'h80, 8'h80, 32'h7F7F_FFFF, 32'h3F80_0000, 32'h0, 1'b1));
    // opposite infinities meet in the reduction
    block_q.push_back(fill_block(8'h80, 8'h7F, 32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000, 1'b1));
    // subnormal scales and underflow of the product
    block_q.push_back(fill_block(8'h7F, 8'h01, 32'h0000_0001, 32'h3F80_0000, 32'h0, 1'b1));
    block_q.push_back(fill_block(8'h7F, 8'h7F, 32'h807F_FFFF, 32'h0080_0000, 32'h0, 1'b1));
    block_q.push_back(fill_block(8'h55, 8'hAA, 32'h0080_0000, 32'h3400_0000, 32'h8000_0001, 1'b1));
    // accumulators are cleared after each result
    block_q.push_back(fill_block(8'h03, 8'h03, 32'h3F80_0000, 32'h3F80_0000, 32'h0, 1'b1));
    for (int i = 0; i < 3; i++) block_q.push_back(rand_block(1'b0));
    block_q.push_back(rand_block(1'b1));

    // random dot products, mostly short, a few long
    while (block_q.size() < 1450) begin
      flen = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int i = 0; i < flen; i++) block_q.push_back(rand_block(i == flen - 1));
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    wait (block_q.size() == 0 && !in_tvalid);
    while (dot_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (failures == 0 && mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // long receiver stall once the stream is well under way
  initial begin
    hold_off = 1'b0;
    wait (blocks_taken >= 300);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(negedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #(12 * 800000);
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      gap_left  <= 0;
    end else if (in_tvalid && !took_block) begin
      // item still on offer
    end else if (gap_left > 0) begin
      in_tvalid <= 1'b0;
      gap_left  <= gap_left - 1;
    end else if (block_q.size() != 0) begin
      cur_block = block_q.pop_front();
      in_tdata  <= {cur_block.bias, cur_block.wgt_scale, cur_block.act_scale,
                    cur_block.wgt, cur_block.act};
      in_tlast  <= cur_block.last;
      in_tvalid <= 1'b1;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: gap_left <= 0;
        5, 6, 7, 8:    gap_left <= $urandom_range(3, 1);
        default:       gap_left <= $urandom_range(40, 10);
      endcase
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // receiver readiness: long stall on request, otherwise random short gaps
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_off) out_tready <= 1'b0;
    else if ($urandom_range(19) == 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(3) != 0);
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      took_block   <= 1'b0;
      blocks_taken <= 0;
      mismatches   <= 0;
      failures     <= 0;
    end else begin
      took_block <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        accumulate_block(cur_block);
        blocks_taken <= blocks_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (dot_q.size() == 0) begin
          if (mismatches + failures < 10) $display("unexpected result %h", out_tdata);
          failures <= failures + 1;
        end else begin
          want = dot_q.pop_front();
          if (out_tdata !== want) begin
            if (mismatches + failures < 10) begin
              $display("result mismatch: expected %h got %h", want, out_tdata);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

>>> sim.f
sv/bsd_pkg.sv
sv/bsd_fadd.sv
sv/bsd_lane.sv
sv/bsd_merge.sv
sv/block_scaled_int8_dot_product.sv
tb/testbench.sv
